// File: design/spiq_pkg.sv
// spiq_pkg: shared types and constants of the stable priority insert queue
// used by spiq_cell and stable_priority_insert_queue; no dependencies
package spiq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam logic [6:0] SENIOR_AGE_RESET = 7'd60;

   // request opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // response status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_POPPED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // priority levels
   localparam logic [1:0] PRIO_NONE   = 2'd0;
   localparam logic [1:0] PRIO_SENIOR = 2'd1;
   localparam logic [1:0] PRIO_DIS    = 2'd2;
   localparam logic [1:0] PRIO_BOTH   = 2'd3;

   typedef struct packed {
      logic [7:0] id;
      logic [6:0] age;
      logic       dis;
      logic [1:0] prio;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      do_insert;
      logic      do_pop;
      entry_type item;
   } cell_ctrl_type;

endpackage

// File: design/stable_priority_insert_queue.sv
// stable_priority_insert_queue: top level, chain of spiq_cell slots plus
// count and response register; depends on spiq_pkg and spiq_cell
//
// usage
//  - req channel carries one word per operation: insert (op 0) with
//    person_id, age and disabled, or pop (op 1) of the head entry
//  - rsp channel returns exactly one word per request: status, popped
//    entry fields, priority level and the entry count after the step
//  - csr port writes senior_age at any edge with csr_wr_en high; it must
//    only change while no request is in flight
//  - every slot of the chain compares the new priority with its own entry
//    in parallel, so a request completes without iterating: one request per
//    cycle while no response is stalled, response in the cycle after acceptance
//  - the response register decouples the sides: a new request is taken
//    whenever the register is empty or is being drained in the same cycle
//  - when rsp_stall holds a response, req_stall is raised and the queue
//    and response stay frozen
//  - reset (synchronous, active high) empties the queue, clears the
//    response valid and restores senior_age to 60; slot contents are not
//    cleared, only slots below the count are ever read
module stable_priority_insert_queue #(
   parameter int QUEUE_DEPTH = spiq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_person_id,
   input  logic [6:0] req_age,
   input  logic       req_disabled,
   // response side
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_id,
   output logic [6:0] rsp_out_age,
   output logic       rsp_out_disabled,
   output logic [1:0] rsp_out_priority,
   output logic [4:0] rsp_entry_count,
   // configuration
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // control registers
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [6:0]    senior_age_ff, senior_age_in;

   // response payload registers
   logic [1:0] status_ff, status_in;
   logic [7:0] out_id_ff, out_id_in;
   logic [6:0] out_age_ff, out_age_in;
   logic       out_dis_ff, out_dis_in;
   logic [1:0] out_prio_ff, out_prio_in;
   logic [CW-1:0] out_count_ff, out_count_in;

   logic          accept;
   logic          is_full;
   logic          is_empty;
   logic [1:0]    new_prio;
   logic          senior;
   spiq_pkg::cell_ctrl_type ctrl;
   spiq_pkg::entry_type     head;

   spiq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   logic                cell_keep  [QUEUE_DEPTH];

   // take a word unless a held response is stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_full  = (count_ff == CW'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // priority level from the disabled flag and the senior threshold
   assign senior = (req_age >= senior_age_ff);
   always_comb begin
      case ({req_disabled, senior})
         2'b11:   new_prio = spiq_pkg::PRIO_BOTH;
         2'b10:   new_prio = spiq_pkg::PRIO_DIS;
         2'b01:   new_prio = spiq_pkg::PRIO_SENIOR;
         default: new_prio = spiq_pkg::PRIO_NONE;
      endcase
   end

   always_comb begin
      ctrl.item.id    = req_person_id;
      ctrl.item.age   = req_age;
      ctrl.item.dis   = req_disabled;
      ctrl.item.prio  = new_prio;
      ctrl.do_insert  = accept && (req_op == spiq_pkg::OP_INSERT) && !is_full;
      ctrl.do_pop     = accept && (req_op == spiq_pkg::OP_POP) && !is_empty;
   end

   // the chain: slot 0 is the head, entries shift toward higher slots
   // on insert and toward the head on pop
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                occupied;
      logic                prev_keep;
      spiq_pkg::entry_type prev_entry;
      spiq_pkg::entry_type next_entry;

      assign occupied = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         assign prev_keep  = 1'b1;
         assign prev_entry = ctrl.item;
      end else begin : g_body
         assign prev_keep  = cell_keep[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      spiq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .keep       (cell_keep[i]),
         .entry      (cell_entry[i])
      );
   end

   assign head = cell_entry[0];

   // next count, config and response
   always_comb begin
      count_in      = count_ff;
      senior_age_in = csr_wr_en ? csr_wr_data : senior_age_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      status_in     = status_ff;
      out_id_in     = out_id_ff;
      out_age_in    = out_age_ff;
      out_dis_in    = out_dis_ff;
      out_prio_in   = out_prio_ff;
      out_count_in  = out_count_ff;

      if (ctrl.do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.do_pop) begin
         count_in = count_ff - CW'(1);
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         out_count_in = count_in;
         out_id_in    = '0;
         out_age_in   = '0;
         out_dis_in   = 1'b0;
         out_prio_in  = new_prio;
         if (req_op == spiq_pkg::OP_INSERT) begin
            status_in = is_full ? spiq_pkg::ST_FULL : spiq_pkg::ST_INSERTED;
         end else if (is_empty) begin
            status_in   = spiq_pkg::ST_EMPTY;
            out_prio_in = spiq_pkg::PRIO_NONE;
         end else begin
            status_in   = spiq_pkg::ST_POPPED;
            out_id_in   = head.id;
            out_age_in  = head.age;
            out_dis_in  = head.dis;
            out_prio_in = head.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         senior_age_ff <= spiq_pkg::SENIOR_AGE_RESET;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
         senior_age_ff <= senior_age_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      out_id_ff    <= out_id_in;
      out_age_ff   <= out_age_in;
      out_dis_ff   <= out_dis_in;
      out_prio_ff  <= out_prio_in;
      out_count_ff <= out_count_in;
   end

   // count shown modulo 32
   logic [CW+4:0] count_wide;
   assign count_wide = {5'b0, out_count_ff};

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_age      = out_age_ff;
   assign rsp_out_disabled = out_dis_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_entry_count  = count_wide[4:0];

endmodule

// File: design/spiq_cell.sv
// spiq_cell: one slot of the sorted chain, holds one entry
// depends on spiq_pkg
module spiq_cell (
   input  logic                   clock,
   input  spiq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   prev_keep,
   input  spiq_pkg::entry_type     prev_entry,
   input  spiq_pkg::entry_type     next_entry,
   output logic                   keep,
   output spiq_pkg::entry_type     entry
);

   spiq_pkg::entry_type entry_ff;
   spiq_pkg::entry_type entry_in;

   // entry stays put when it ranks at or above the new one
   assign keep  = occupied && (ctrl.item.prio <= entry_ff.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_pop) begin
         entry_in = next_entry;
      end else if (ctrl.do_insert && !keep) begin
         entry_in = prev_keep ? ctrl.item : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
